/* rtl/core/obstacle_aware_drive_steering_assert.svh */
// Assertion macros shared by the steering checker.
// Depends on nothing; include by bare file name.
`ifndef OBSTACLE_AWARE_DRIVE_STEERING_ASSERT_SVH
`define OBSTACLE_AWARE_DRIVE_STEERING_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define OADS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("steering check failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define OADS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("steering check failed: next-cycle implication");

`endif

/* rtl/core/oads_pkg.sv */
// Shared types and constants of the obstacle-aware drive steering block.
// Depends on nothing; used by every module of the block.
package oads_pkg;

   localparam int MODE_BITS        = 8;
   localparam int ACTION_BITS      = 2;
   localparam int CFG_SPEED_BITS   = 10;
   localparam int CFG_DIST_BITS    = 10;
   localparam int CFG_TIMEOUT_BITS = 16;
   localparam int CFG_GAIN_BITS    = 4;
   localparam int CSR_INDEX_BITS   = 3;
   localparam int CSR_DATA_BITS    = 16;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_STOP  = 2'd0,
      ACT_FWD   = 2'd1,
      ACT_LEFT  = 2'd2,
      ACT_RIGHT = 2'd3
   } action_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_NORMAL_BASE  = 3'd0,
      REG_NORMAL_MAX   = 3'd1,
      REG_SLOW_BASE    = 3'd2,
      REG_SLOW_MAX     = 3'd3,
      REG_MIN_SPEED    = 3'd4,
      REG_FRONT_STOP   = 3'd5,
      REG_TURN_TIMEOUT = 3'd6,
      REG_STEER_GAIN   = 3'd7
   } csr_index_type;

   localparam logic [MODE_BITS-1:0] MODE_STOP = 8'd0;
   localparam logic [MODE_BITS-1:0] MODE_SLOW = 8'd1;

   // Range thresholds, in cm
   localparam int NO_ECHO_SUB = 40;
   localparam int EXIT_FRONT  = 45;
   localparam int EXIT_SIDE   = 15;
   localparam int SIDE_NEAR   = 10;
   localparam int DIFF_LIMIT  = 35;

   // Fixed wheel speeds
   localparam logic [CFG_SPEED_BITS-1:0] TURN_SPEED = 10'd530;
   localparam logic [CFG_SPEED_BITS-1:0] AVOID_FAST = 10'd550;
   localparam logic [CFG_SPEED_BITS-1:0] AVOID_SLOW = 10'd150;

   typedef struct packed {
      logic [CFG_SPEED_BITS-1:0]   normal_base;
      logic [CFG_SPEED_BITS-1:0]   normal_max;
      logic [CFG_SPEED_BITS-1:0]   slow_base;
      logic [CFG_SPEED_BITS-1:0]   slow_max;
      logic [CFG_SPEED_BITS-1:0]   min_speed;
      logic [CFG_DIST_BITS-1:0]    front_stop;
      logic [CFG_TIMEOUT_BITS-1:0] turn_timeout;
      logic [CFG_GAIN_BITS-1:0]    steer_gain;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      normal_base:  10'd450,
      normal_max:   10'd650,
      slow_base:    10'd350,
      slow_max:     10'd500,
      min_speed:    10'd200,
      front_stop:   10'd37,
      turn_timeout: 16'd1500,
      steer_gain:   4'd5
   };

   // Turn state update requested by the steering logic
   typedef struct packed {
      logic turning;
      logic spin_left;
      logic load_start;
   } turn_ctl_type;

endpackage

/* rtl/core/oads_csr.sv */
// Configuration register file of the drive steering block.
// Depends on oads_pkg for the register layout and index codes.
module oads_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [oads_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [oads_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output oads_pkg::cfg_type                    cfg
);

   oads_pkg::cfg_type cfg_ff;
   oads_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (oads_pkg::csr_index_type'(csr_index))
            oads_pkg::REG_NORMAL_BASE:  cfg_in.normal_base  = csr_wdata[9:0];
            oads_pkg::REG_NORMAL_MAX:   cfg_in.normal_max   = csr_wdata[9:0];
            oads_pkg::REG_SLOW_BASE:    cfg_in.slow_base    = csr_wdata[9:0];
            oads_pkg::REG_SLOW_MAX:     cfg_in.slow_max     = csr_wdata[9:0];
            oads_pkg::REG_MIN_SPEED:    cfg_in.min_speed    = csr_wdata[9:0];
            oads_pkg::REG_FRONT_STOP:   cfg_in.front_stop   = csr_wdata[9:0];
            oads_pkg::REG_TURN_TIMEOUT: cfg_in.turn_timeout = csr_wdata[15:0];
            oads_pkg::REG_STEER_GAIN:   cfg_in.steer_gain   = csr_wdata[3:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= oads_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/core/oads_steer.sv */
// Combinational steering decision: turn tracking, avoidance, proportional split.
// Depends on oads_pkg for action codes, constants and the config struct.
module oads_steer #(
   parameter int DIST_BITS  = 10,
   parameter int SPEED_BITS = 10,
   parameter int TIME_BITS  = 32
) (
   input  oads_pkg::cfg_type                 cfg,
   input  logic                              turning,
   input  logic                              spin_left,
   input  logic [TIME_BITS-1:0]              turn_start_ms,
   input  logic [oads_pkg::MODE_BITS-1:0]    drive_mode,
   input  logic [TIME_BITS-1:0]              now_ms,
   input  logic [DIST_BITS-1:0]              left_distance,
   input  logic [DIST_BITS-1:0]              front_distance,
   input  logic [DIST_BITS-1:0]              right_distance,
   output oads_pkg::action_type              motor_action,
   output logic [SPEED_BITS-1:0]             left_speed,
   output logic [SPEED_BITS-1:0]             right_speed,
   output logic                              in_turn,
   output oads_pkg::turn_ctl_type            turn_ctl
);

   localparam int CW  = oads_pkg::CFG_SPEED_BITS;
   localparam int CMP_W = (DIST_BITS > oads_pkg::CFG_DIST_BITS) ? DIST_BITS
                                                                 : oads_pkg::CFG_DIST_BITS;
   localparam int SW  = (SPEED_BITS > CW) ? SPEED_BITS : CW;
   localparam logic [SW-1:0] SPD_MAX = SW'((33'd1 << SPEED_BITS) - 33'd1);
   localparam logic [DIST_BITS-1:0] SUB_D   = DIST_BITS'(oads_pkg::NO_ECHO_SUB);
   localparam logic [DIST_BITS-1:0] FRONT_D = DIST_BITS'(oads_pkg::EXIT_FRONT);
   localparam logic [DIST_BITS-1:0] SIDE_D  = DIST_BITS'(oads_pkg::EXIT_SIDE);
   localparam logic [DIST_BITS-1:0] NEAR_D  = DIST_BITS'(oads_pkg::SIDE_NEAR);
   localparam logic signed [DIST_BITS:0] LIM_P = (DIST_BITS+1)'(oads_pkg::DIFF_LIMIT);
   localparam logic signed [DIST_BITS:0] LIM_N = -LIM_P;

   function automatic logic [SPEED_BITS-1:0] sat_speed(input logic [CW-1:0] v);
      logic [SW-1:0] v_w;
      v_w = SW'(v);
      return (v_w > SPD_MAX) ? SPEED_BITS'(SPD_MAX) : SPEED_BITS'(v_w);
   endfunction

   logic [TIME_BITS-1:0]       elapsed;
   logic                       timed_out;
   logic                       path_clear;
   logic [DIST_BITS-1:0]       l_sub, f_sub, r_sub;
   logic                       front_hit;
   logic                       near_left, near_right;
   logic signed [DIST_BITS:0]  diff;
   logic signed [DIST_BITS:0]  diff_lim;
   logic signed [11:0]         diff_x, gain_x, offs;
   logic signed [11:0]         base_x, top_x, low_x;
   logic signed [11:0]         ls_raw, rs_raw, ls_top, rs_top, ls_clip, rs_clip;
   logic [CW-1:0]              base_sel, top_sel;
   logic [CW-1:0]              spd_l, spd_r;

   assign elapsed    = now_ms - turn_start_ms;
   assign timed_out  = elapsed >= TIME_BITS'(cfg.turn_timeout);
   // exit test uses the raw ranges, before no-echo substitution
   assign path_clear = (front_distance >= FRONT_D) && (left_distance >= SIDE_D)
                       && (right_distance >= SIDE_D);

   assign l_sub = (left_distance  == '0) ? SUB_D : left_distance;
   assign f_sub = (front_distance == '0) ? SUB_D : front_distance;
   assign r_sub = (right_distance == '0) ? SUB_D : right_distance;

   assign front_hit  = CMP_W'(f_sub) <= CMP_W'(cfg.front_stop);
   assign near_left  = l_sub <= NEAR_D;
   assign near_right = r_sub <= NEAR_D;

   // proportional split of the base speed
   assign diff     = $signed({1'b0, l_sub}) - $signed({1'b0, r_sub});
   assign diff_lim = (diff > LIM_P) ? LIM_P : ((diff < LIM_N) ? LIM_N : diff);
   assign diff_x   = 12'(diff_lim);
   assign gain_x   = $signed({8'd0, cfg.steer_gain});
   assign offs     = diff_x * gain_x;

   assign base_sel = (drive_mode == oads_pkg::MODE_SLOW) ? cfg.slow_base : cfg.normal_base;
   assign top_sel  = (drive_mode == oads_pkg::MODE_SLOW) ? cfg.slow_max  : cfg.normal_max;
   assign base_x   = $signed({2'b00, base_sel});
   assign top_x    = $signed({2'b00, top_sel});
   assign low_x    = $signed({2'b00, cfg.min_speed});

   assign ls_raw  = base_x - offs;
   assign rs_raw  = base_x + offs;
   // upper clamp first, lower clamp last so min wins
   assign ls_top  = (ls_raw > top_x) ? top_x : ls_raw;
   assign rs_top  = (rs_raw > top_x) ? top_x : rs_raw;
   assign ls_clip = (ls_top < low_x) ? low_x : ls_top;
   assign rs_clip = (rs_top < low_x) ? low_x : rs_top;

   always_comb begin
      motor_action = oads_pkg::ACT_STOP;
      spd_l        = '0;
      spd_r        = '0;
      in_turn      = 1'b0;
      turn_ctl     = '{turning: turning, spin_left: spin_left, load_start: 1'b0};
      if (turning) begin
         if (timed_out || path_clear) begin
            turn_ctl.turning = 1'b0;
         end else begin
            motor_action = spin_left ? oads_pkg::ACT_LEFT : oads_pkg::ACT_RIGHT;
            spd_l        = oads_pkg::TURN_SPEED;
            spd_r        = oads_pkg::TURN_SPEED;
            in_turn      = 1'b1;
         end
      end else if (drive_mode == oads_pkg::MODE_STOP) begin
         motor_action = oads_pkg::ACT_STOP;
      end else if (front_hit) begin
         turn_ctl.spin_left  = !(l_sub > r_sub);
         turn_ctl.load_start = 1'b1;
         if (cfg.turn_timeout != '0) begin
            turn_ctl.turning = 1'b1;
            motor_action = (!(l_sub > r_sub)) ? oads_pkg::ACT_LEFT : oads_pkg::ACT_RIGHT;
            spd_l        = oads_pkg::TURN_SPEED;
            spd_r        = oads_pkg::TURN_SPEED;
            in_turn      = 1'b1;
         end
      end else if (near_left) begin
         motor_action = oads_pkg::ACT_FWD;
         spd_l        = oads_pkg::AVOID_FAST;
         spd_r        = oads_pkg::AVOID_SLOW;
      end else if (near_right) begin
         motor_action = oads_pkg::ACT_FWD;
         spd_l        = oads_pkg::AVOID_SLOW;
         spd_r        = oads_pkg::AVOID_FAST;
      end else begin
         motor_action = oads_pkg::ACT_FWD;
         spd_l        = CW'(ls_clip);
         spd_r        = CW'(rs_clip);
      end
   end

   assign left_speed  = sat_speed(spd_l);
   assign right_speed = sat_speed(spd_r);

endmodule

/* rtl/core/obstacle_aware_drive_steering.sv */
// Top level of the obstacle-aware drive steering block.
// Depends on oads_pkg, oads_csr and oads_steer.

// The block takes one sensor transfer per clock cycle while rsp_tready is high
// and returns exactly one motor command transfer for each. Every transfer
// passes an input register and a result register; the steering decision sits
// between the two registers and the turn state (turning flag, spin direction,
// turn start time) updates as each item moves into the result register, so the
// next item already sees it. With rsp_tready held high the block sustains one
// item per cycle; a stalled result holds in the result register while one more
// item waits in the input register. Configuration writes on the csr_ port take
// effect at the next edge.
module obstacle_aware_drive_steering #(
   parameter int DIST_BITS  = 10,
   parameter int SPEED_BITS = 10,
   parameter int TIME_BITS  = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata fields, low bit up: drive_mode, now_ms, left_distance,
   // front_distance, right_distance, zero pad to whole bytes
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((oads_pkg::MODE_BITS + TIME_BITS + 3 * DIST_BITS + 7) / 8) * 8 - 1:0]
                                               req_tdata,
   // rsp_tdata fields, low bit up: motor_action, left_speed, right_speed,
   // in_turn, zero pad to whole bytes
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [((oads_pkg::ACTION_BITS + 2 * SPEED_BITS + 1 + 7) / 8) * 8 - 1:0]
                                               rsp_tdata,
   input  logic                                csr_we,
   input  logic [oads_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [oads_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int MB       = oads_pkg::MODE_BITS;
   localparam int REQ_BITS = MB + TIME_BITS + 3 * DIST_BITS;
   localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS = oads_pkg::ACTION_BITS + 2 * SPEED_BITS + 1;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;
   localparam int TIME_LSB  = MB;
   localparam int LEFT_LSB  = TIME_LSB + TIME_BITS;
   localparam int FRONT_LSB = LEFT_LSB + DIST_BITS;
   localparam int RIGHT_LSB = FRONT_LSB + DIST_BITS;

   oads_pkg::cfg_type       cfg;
   oads_pkg::turn_ctl_type  turn_ctl;
   oads_pkg::action_type    act;
   logic [SPEED_BITS-1:0]   ls, rs;
   logic                    turn_flag;

   // input register
   logic                    req_valid_ff, req_valid_in;
   logic [MB-1:0]           mode_ff;
   logic [TIME_BITS-1:0]    now_ff;
   logic [DIST_BITS-1:0]    left_ff, front_ff, right_ff;

   // turn state
   logic                    turning_ff, turning_in;
   logic                    spin_left_ff, spin_left_in;
   logic [TIME_BITS-1:0]    start_ff, start_in;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]        rsp_data_ff, rsp_data_in;

   logic                    req_take;
   logic                    advance;

   oads_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   oads_steer #(
      .DIST_BITS  (DIST_BITS),
      .SPEED_BITS (SPEED_BITS),
      .TIME_BITS  (TIME_BITS)
   ) u_steer (
      .cfg            (cfg),
      .turning        (turning_ff),
      .spin_left      (spin_left_ff),
      .turn_start_ms  (start_ff),
      .drive_mode     (mode_ff),
      .now_ms         (now_ff),
      .left_distance  (left_ff),
      .front_distance (front_ff),
      .right_distance (right_ff),
      .motor_action   (act),
      .left_speed     (ls),
      .right_speed    (rs),
      .in_turn        (turn_flag),
      .turn_ctl       (turn_ctl)
   );

   // advance the held item when the result register is free or draining
   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign req_valid_in = req_take || (req_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);
   assign rsp_data_in  = RSP_W'({turn_flag, rs, ls, act});

   // commit turn state only when the item leaves the input register
   assign turning_in   = advance ? turn_ctl.turning   : turning_ff;
   assign spin_left_in = advance ? turn_ctl.spin_left : spin_left_ff;
   assign start_in     = (advance && turn_ctl.load_start) ? now_ff : start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         turning_ff   <= 1'b0;
         spin_left_ff <= 1'b0;
         start_ff     <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         turning_ff   <= turning_in;
         spin_left_ff <= spin_left_in;
         start_ff     <= start_in;
      end
   end

   // payload registers: load on transfer, hold otherwise
   always_ff @(posedge clock) begin
      if (req_take) begin
         mode_ff  <= req_tdata[MB-1:0];
         now_ff   <= req_tdata[TIME_LSB  +: TIME_BITS];
         left_ff  <= req_tdata[LEFT_LSB  +: DIST_BITS];
         front_ff <= req_tdata[FRONT_LSB +: DIST_BITS];
         right_ff <= req_tdata[RIGHT_LSB +: DIST_BITS];
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* rtl/core/oads_checker.sv */
// Port-level checker for the drive steering block, bound to its top level.
// Depends on oads_pkg and the assertion macro header.
`include "obstacle_aware_drive_steering_assert.svh"

module oads_checker #(
   parameter int DIST_BITS  = 10,
   parameter int SPEED_BITS = 10,
   parameter int TIME_BITS  = 32
) (
   input logic             clock,
   input logic             reset,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [((oads_pkg::ACTION_BITS + 2 * SPEED_BITS + 1 + 7) / 8) * 8 - 1:0]
                           rsp_tdata
);

   localparam int RSP_BITS = oads_pkg::ACTION_BITS + 2 * SPEED_BITS + 1;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;
   localparam int LS_LSB   = oads_pkg::ACTION_BITS;
   localparam int RS_LSB   = LS_LSB + SPEED_BITS;
   localparam int TURN_BIT = RS_LSB + SPEED_BITS;
   localparam int CHK_BITS = DIST_BITS + TIME_BITS;

   logic [oads_pkg::ACTION_BITS-1:0] act;
   logic [SPEED_BITS-1:0]            ls, rs;
   logic                             turn_flag;
   logic [CHK_BITS-1:0]              unused_width;
   logic                             stalled;
   logic                             stop_seen;
   logic                             speeds_zero;
   logic                             spin_cmd;

   assign act          = rsp_tdata[oads_pkg::ACTION_BITS-1:0];
   assign ls           = rsp_tdata[LS_LSB +: SPEED_BITS];
   assign rs           = rsp_tdata[RS_LSB +: SPEED_BITS];
   assign turn_flag    = rsp_tdata[TURN_BIT];
   assign unused_width = '0;
   assign stalled      = rsp_tvalid && !rsp_tready;
   assign stop_seen    = rsp_tvalid && (act == oads_pkg::ACT_STOP);
   assign speeds_zero  = (ls == '0) && (rs == '0) && (unused_width == '0);
   assign spin_cmd     = (act == oads_pkg::ACT_LEFT) || (act == oads_pkg::ACT_RIGHT);

   // stalled result holds
   `OADS_ASSERT_NEXT(a_rsp_hold, clock, reset, stalled, rsp_tvalid && $stable(rsp_tdata))

   // stop commands carry zero wheel speeds
   `OADS_ASSERT_IMPL(a_stop_zero, clock, reset, stop_seen, speeds_zero)

   // in_turn is set exactly on spin commands
   `OADS_ASSERT_IMPL(a_turn_spin, clock, reset, rsp_tvalid, turn_flag == spin_cmd)

   // a point turn drives both wheels alike
   `OADS_ASSERT_IMPL(a_turn_even, clock, reset, rsp_tvalid && turn_flag, ls == rs)

endmodule

bind obstacle_aware_drive_steering oads_checker #(
   .DIST_BITS  (DIST_BITS),
   .SPEED_BITS (SPEED_BITS),
   .TIME_BITS  (TIME_BITS)
) u_oads_checker (.*);
